[rtl/strict_priority_four_class_server_defines.svh]
// strict_priority_four_class_server_defines.svh
// assertion macros for the strict priority server rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef STRICT_PRIORITY_FOUR_CLASS_SERVER_DEFINES_SVH
`define STRICT_PRIORITY_FOUR_CLASS_SERVER_DEFINES_SVH

// property checked on every clock edge outside reset
`define SPFCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked on every clock edge outside reset
`define SPFCS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/spfcs_pkg.sv]
// spfcs_pkg.sv
// shared types, codes and defaults of the strict priority server
// no dependencies
`default_nettype none

package spfcs_pkg;

  // defaults and fixed field widths
  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned ID_BITS_DEF     = 16;
  localparam int unsigned ID_FIELD_W      = 16;
  localparam int unsigned DUR_W           = 16;
  localparam int unsigned TIME_W          = 32;
  localparam int unsigned NUM_CLASSES     = 4;

  // item modes
  localparam logic MODE_ARRIVAL = 1'b0;
  localparam logic MODE_TICK    = 1'b1;

  // service classes: regular, silver, gold, platinum
  localparam logic [1:0] CLS_REGULAR  = 2'd0;
  localparam logic [1:0] CLS_SILVER   = 2'd1;
  localparam logic [1:0] CLS_GOLD     = 2'd2;
  localparam logic [1:0] CLS_PLATINUM = 2'd3;

  typedef enum logic [2:0] {
    EV_QUEUED   = 3'd0,
    EV_DROPPED  = 3'd1,
    EV_ANSWERED = 3'd2,
    EV_BUSY     = 3'd3,
    EV_IDLE     = 3'd4
  } event_kind_e;

  typedef struct packed {
    logic                    mode;
    logic [ID_FIELD_W-1:0]   caller_id;
    logic [1:0]              service_class;
    logic [DUR_W-1:0]        call_duration;
  } in_item_t;

  typedef struct packed {
    event_kind_e             event_kind;
    logic [ID_FIELD_W-1:0]   served_id;
    logic [1:0]              served_class;
    logic [TIME_W-1:0]       tick_now;
    logic                    queues_empty;
  } out_item_t;

  // per class queue control and status
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;

  typedef struct packed {
    logic nonempty;
    logic full;
    logic last;
  } q_stat_t;

endpackage

`default_nettype wire

[rtl/spfcs_queue.sv]
// spfcs_queue.sv
// one class fifo: entry memory, pointers, count and a registered head read
// depends on spfcs_pkg and strict_priority_four_class_server_defines.svh
`default_nettype none
`include "strict_priority_four_class_server_defines.svh"

module spfcs_queue #(
  parameter int unsigned DEPTH = spfcs_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned ID_W  = spfcs_pkg::ID_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire spfcs_pkg::q_ctl_t             ctl_i,
  input  wire logic [ID_W-1:0]               wr_id_i,
  input  wire logic [spfcs_pkg::DUR_W-1:0]   wr_dur_i,
  output spfcs_pkg::q_stat_t                 stat_o,
  output logic [ID_W-1:0]                    head_id_o,
  output logic [spfcs_pkg::DUR_W-1:0]        head_dur_o
);

  localparam int unsigned PtrW   = $clog2(DEPTH);
  localparam int unsigned CntW   = $clog2(DEPTH + 1);
  localparam int unsigned EntryW = ID_W + spfcs_pkg::DUR_W;

  logic [EntryW-1:0] mem_q [DEPTH];
  logic [EntryW-1:0] rd_q;
  logic [EntryW-1:0] wr_data;
  logic [PtrW-1:0]   head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]   count_q, count_d;

  assign wr_data = {wr_id_i, wr_dur_i};

  // pointer and count update with wrap at depth
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (ctl_i.push) begin
      tail_d  = (tail_q == PtrW'(DEPTH - 1)) ? '0 : PtrW'(tail_q + PtrW'(1));
      count_d = CntW'(count_q + CntW'(1));
    end
    if (ctl_i.pop) begin
      head_d  = (head_q == PtrW'(DEPTH - 1)) ? '0 : PtrW'(head_q + PtrW'(1));
      count_d = CntW'(count_q - CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // entry memory write
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem_q[tail_q] <= wr_data;
    end
  end

  // head read follows the next head pointer, bypassing a same cycle write
  always_ff @(posedge clk_i) begin
    if (ctl_i.push && (tail_q == head_d)) begin
      rd_q <= wr_data;
    end else begin
      rd_q <= mem_q[head_d];
    end
  end

  assign head_id_o       = rd_q[EntryW-1:spfcs_pkg::DUR_W];
  assign head_dur_o      = rd_q[spfcs_pkg::DUR_W-1:0];
  assign stat_o.nonempty = (count_q != '0);
  assign stat_o.full     = (count_q == CntW'(DEPTH));
  assign stat_o.last     = (count_q == CntW'(1));

  // checks
  `SPFCS_ASSERT(a_count_in_range, count_q <= CntW'(DEPTH), "queue count above depth")
  `SPFCS_ASSERT_IMPL(a_no_pop_empty, ctl_i.pop, count_q != '0, "pop from empty queue")
  `SPFCS_ASSERT_IMPL(a_no_push_full, ctl_i.push, count_q != CntW'(DEPTH), "push to full queue")

endmodule

`default_nettype wire

[rtl/strict_priority_four_class_server.sv]
// strict_priority_four_class_server.sv
// top level: input register, priority pick, server timing, result register
// depends on spfcs_pkg, spfcs_queue and strict_priority_four_class_server_defines.svh
//
//   channel   direction   handshake                 payload
//   in        input       in_valid_i / in_stall_o   in_data_i  (spfcs_pkg::in_item_t)
//   out       output      out_valid_o / out_stall_i out_data_o (spfcs_pkg::out_item_t)
//
// one item per cycle sustained while no result stalls; each item gives one result after its transfer
// the rate is set by the single pass from the input register to the result register
// reset clears the queues, the tick and the free time at once; no clearing pass is needed
// a stalled result holds the pipe and in_stall_o rises once the input register is full
`default_nettype none
`include "strict_priority_four_class_server_defines.svh"

module strict_priority_four_class_server #(
  parameter int unsigned QUEUE_DEPTH = spfcs_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned ID_BITS     = spfcs_pkg::ID_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire spfcs_pkg::in_item_t  in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output spfcs_pkg::out_item_t      out_data_o
);

  localparam int unsigned IdW = (ID_BITS < spfcs_pkg::ID_FIELD_W) ? ID_BITS
                                                                  : spfcs_pkg::ID_FIELD_W;
  localparam int unsigned NumCls = spfcs_pkg::NUM_CLASSES;
  localparam int unsigned TimeW  = spfcs_pkg::TIME_W;

  localparam int unsigned CLS_PLATINUM_IDX = int'(spfcs_pkg::CLS_PLATINUM);
  localparam int unsigned CLS_GOLD_IDX     = int'(spfcs_pkg::CLS_GOLD);
  localparam int unsigned CLS_SILVER_IDX   = int'(spfcs_pkg::CLS_SILVER);

  logic                 s1_valid_q, s1_valid_d;
  spfcs_pkg::in_item_t  s1_q;
  logic                 out_valid_q, out_valid_d;
  spfcs_pkg::out_item_t out_q, out_d;
  logic [TimeW-1:0]     tick_q, tick_d, free_q, free_d;

  spfcs_pkg::q_ctl_t    ctl [NumCls];
  spfcs_pkg::q_stat_t   stat [NumCls];
  logic [IdW-1:0]       head_id [NumCls];
  logic [spfcs_pkg::DUR_W-1:0] head_dur [NumCls];

  logic                 adv, in_xfer, is_tick, busy, any_waiting, arr_full;
  logic                 do_push, do_pop, all_empty;
  logic [1:0]           pick;
  logic [NumCls-1:0]    nonempty;
  logic [TimeW:0]       end_sum;

  // handshake: the item in the input register moves on when the result slot frees
  assign adv        = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !adv;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // class fifos
  for (genvar c = 0; c < NumCls; c++) begin : g_queue
    spfcs_queue #(
      .DEPTH (QUEUE_DEPTH),
      .ID_W  (IdW)
    ) u_queue (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl[c]),
      .wr_id_i    (s1_q.caller_id[IdW-1:0]),
      .wr_dur_i   (s1_q.call_duration),
      .stat_o     (stat[c]),
      .head_id_o  (head_id[c]),
      .head_dur_o (head_dur[c])
    );
    assign nonempty[c] = stat[c].nonempty;
  end

  // highest non-empty class wins
  always_comb begin
    if (nonempty[CLS_PLATINUM_IDX]) begin
      pick = spfcs_pkg::CLS_PLATINUM;
    end else if (nonempty[CLS_GOLD_IDX]) begin
      pick = spfcs_pkg::CLS_GOLD;
    end else if (nonempty[CLS_SILVER_IDX]) begin
      pick = spfcs_pkg::CLS_SILVER;
    end else begin
      pick = spfcs_pkg::CLS_REGULAR;
    end
  end

  // arrival and tick decisions
  assign is_tick     = (s1_q.mode == spfcs_pkg::MODE_TICK);
  assign busy        = (tick_q < free_q);
  assign any_waiting = |nonempty;
  assign arr_full    = stat[s1_q.service_class].full;
  assign do_push     = adv && !is_tick && !arr_full;
  assign do_pop      = adv && is_tick && !busy && any_waiting;

  always_comb begin
    all_empty = 1'b1;
    for (int c = 0; c < NumCls; c++) begin
      ctl[c].push = do_push && (s1_q.service_class == 2'(c));
      ctl[c].pop  = do_pop && (pick == 2'(c));
      if ((stat[c].nonempty && !(stat[c].last && ctl[c].pop)) || ctl[c].push) begin
        all_empty = 1'b0;
      end
    end
  end

  // server end time and tick, both saturating
  assign end_sum = {1'b0, tick_q} + (TimeW + 1)'(head_dur[pick]);

  always_comb begin
    free_d = free_q;
    if (do_pop) begin
      free_d = end_sum[TimeW] ? '1 : end_sum[TimeW-1:0];
    end
    tick_d = tick_q;
    if (adv && is_tick && (tick_q != '1)) begin
      tick_d = TimeW'(tick_q + TimeW'(1));
    end
  end

  // result word
  always_comb begin
    out_d.tick_now     = tick_q;
    out_d.queues_empty = all_empty;
    out_d.served_id    = '0;
    out_d.served_class = spfcs_pkg::CLS_REGULAR;
    if (!is_tick) begin
      out_d.served_id    = spfcs_pkg::ID_FIELD_W'(s1_q.caller_id[IdW-1:0]);
      out_d.served_class = s1_q.service_class;
      out_d.event_kind   = arr_full ? spfcs_pkg::EV_DROPPED : spfcs_pkg::EV_QUEUED;
    end else if (busy) begin
      out_d.event_kind   = spfcs_pkg::EV_BUSY;
    end else if (!any_waiting) begin
      out_d.event_kind   = spfcs_pkg::EV_IDLE;
    end else begin
      out_d.served_id    = spfcs_pkg::ID_FIELD_W'(head_id[pick]);
      out_d.served_class = pick;
      out_d.event_kind   = spfcs_pkg::EV_ANSWERED;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      tick_q      <= '0;
      free_q      <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      tick_q      <= tick_d;
      free_q      <= free_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_q <= in_data_i;
    end
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  `SPFCS_ASSERT(a_tick_monotonic, tick_q >= $past(tick_q), "tick went backward")
  `SPFCS_ASSERT_IMPL(a_answer_when_free, do_pop, tick_q >= free_q, "call answered while busy")
  `SPFCS_ASSERT_IMPL(a_result_held, $past(out_valid_q && out_stall_i), out_valid_q && $stable(out_q), "stalled result changed")

endmodule

`default_nettype wire
